>>> rtl/core/rle_column_directory_builder_top_macros.svh
// assertion macros for the column directory builder
`ifndef RLE_COLUMN_DIRECTORY_BUILDER_TOP_MACROS_SVH
`define RLE_COLUMN_DIRECTORY_BUILDER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define RCDB_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
`define RCDB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define RCDB_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define RCDB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/rcdb_pkg.sv
// shared types, constants and helpers of the column directory builder
package rcdb_pkg;

	localparam int unsigned OFS_W   = 24;
	localparam int unsigned POS_W   = 12;
	localparam int unsigned WORD_W  = 16;
	localparam int unsigned SIDE_W  = 13;
	localparam int unsigned MAX_SIDE = 4096;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_Z = 2'd1;

	typedef enum logic [1:0] {
		PH_COUNT = 2'd0,
		PH_TEX   = 2'd1,
		PH_ALL   = 2'd3
	} phase_t;

	typedef struct packed {
		logic [POS_W-1:0]  x;
		logic [POS_W-1:0]  z;
		logic [OFS_W-1:0]  offset;
		logic [WORD_W-1:0] count;
		logic [WORD_W-1:0] frw;
		logic              status;
		logic              last;
	} entry_t;

	typedef struct packed {
		logic first;
		logic second;
	} push_t;

	// 0 counts as 1, anything above the largest side saturates
	function automatic logic [SIDE_W-1:0] side_clamp(input logic [SIDE_W-1:0] v);
		logic [SIDE_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = SIDE_W'(1);
		end else if (v > SIDE_W'(MAX_SIDE)) begin
			r = SIDE_W'(MAX_SIDE);
		end
		return r;
	endfunction

endpackage

>>> rtl/core/rcdb_front.sv
// front end: tracks column boundaries in the word stream and forms directory entries
module rcdb_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  logic [rcdb_pkg::WORD_W-1:0]       slab_word,
	input  logic                              end_of_stream,
	input  logic [rcdb_pkg::SIDE_W-1:0]       side_x,
	input  logic [rcdb_pkg::SIDE_W-1:0]       side_z,
	output rcdb_pkg::push_t                   push,
	output rcdb_pkg::entry_t                  slot0,
	output rcdb_pkg::entry_t                  slot1
);

	logic [rcdb_pkg::POS_W-1:0]  pos_x_q, pos_x_d;
	logic [rcdb_pkg::POS_W-1:0]  pos_z_q, pos_z_d;
	logic [rcdb_pkg::OFS_W-1:0]  word_ofs_q, word_ofs_d;
	logic [rcdb_pkg::OFS_W-1:0]  ncs_q, ncs_d;
	rcdb_pkg::phase_t            phase_q, phase_d;
	logic                        pend_valid_q, pend_valid_d;
	logic [rcdb_pkg::OFS_W-1:0]  pend_ofs_q, pend_ofs_d;
	logic [rcdb_pkg::WORD_W-1:0] pend_cnt_q, pend_cnt_d;
	logic [rcdb_pkg::POS_W-1:0]  pend_x_q, pend_x_d;
	logic [rcdb_pkg::POS_W-1:0]  pend_z_q, pend_z_d;
	logic                        done_q, done_d;

	logic                        live;
	logic                        hit_pend;
	logic                        fin_hit;
	logic                        x_wrap;
	logic                        z_wrap;
	logic                        have_a, have_b, have_c;
	rcdb_pkg::entry_t            ent_a, ent_b, ent_c;

	assign live     = accept && !done_q;
	assign hit_pend = pend_valid_q && (phase_q != rcdb_pkg::PH_TEX)
		&& (word_ofs_q == pend_ofs_q + rcdb_pkg::OFS_W'(2));
	assign fin_hit  = hit_pend && (phase_q == rcdb_pkg::PH_ALL);
	assign x_wrap   = ({1'b0, pos_x_q} + rcdb_pkg::SIDE_W'(1)) >= side_x;
	assign z_wrap   = ({1'b0, pos_z_q} + rcdb_pkg::SIDE_W'(1)) >= side_z;

	// next state
	always_comb begin
		pos_x_d      = pos_x_q;
		pos_z_d      = pos_z_q;
		word_ofs_d   = word_ofs_q;
		ncs_d        = ncs_q;
		phase_d      = phase_q;
		pend_valid_d = pend_valid_q;
		pend_ofs_d   = pend_ofs_q;
		pend_cnt_d   = pend_cnt_q;
		pend_x_d     = pend_x_q;
		pend_z_d     = pend_z_q;
		done_d       = done_q;
		if (live) begin
			if (hit_pend) begin
				pend_valid_d = 1'b0;
			end
			if (fin_hit) begin
				done_d = 1'b1;
			end else begin
				unique case (phase_q)
					rcdb_pkg::PH_COUNT: begin
						if (word_ofs_q == ncs_q) begin
							pend_valid_d = 1'b1;
							pend_ofs_d   = word_ofs_q;
							pend_cnt_d   = slab_word;
							pend_x_d     = pos_x_q;
							pend_z_d     = pos_z_q;
							phase_d      = (x_wrap && z_wrap) ? rcdb_pkg::PH_ALL
								: rcdb_pkg::PH_TEX;
						end
					end
					rcdb_pkg::PH_TEX: begin
						if (word_ofs_q == pend_ofs_q + rcdb_pkg::OFS_W'(1)) begin
							ncs_d = pend_ofs_q + rcdb_pkg::OFS_W'(pend_cnt_q)
								+ rcdb_pkg::OFS_W'(slab_word) + rcdb_pkg::OFS_W'(2);
							if (x_wrap) begin
								pos_x_d = '0;
								pos_z_d = z_wrap ? '0 : pos_z_q + rcdb_pkg::POS_W'(1);
							end else begin
								pos_x_d = pos_x_q + rcdb_pkg::POS_W'(1);
							end
							phase_d = rcdb_pkg::PH_COUNT;
						end
					end
					rcdb_pkg::PH_ALL: begin
					end
					default: begin
					end
				endcase
				if (end_of_stream) begin
					pend_valid_d = 1'b0;
					done_d       = 1'b1;
				end
			end
			word_ofs_d = word_ofs_q + rcdb_pkg::OFS_W'(1);
		end
	end

	// entries and push flags
	always_comb begin
		have_a = live && hit_pend;
		have_b = live && !fin_hit && end_of_stream && (pend_valid_q && !hit_pend
			|| phase_q == rcdb_pkg::PH_COUNT && word_ofs_q == ncs_q);
		have_c = live && !fin_hit && end_of_stream && (phase_d == rcdb_pkg::PH_COUNT);

		ent_a = '{x: pend_x_q, z: pend_z_q, offset: pend_ofs_q, count: pend_cnt_q,
			frw: slab_word, status: 1'b0, last: 1'b0};
		ent_b = '{x: pend_x_d, z: pend_z_d, offset: pend_ofs_d, count: pend_cnt_d,
			frw: '0, status: 1'b1, last: 1'b0};
		ent_c = '{x: pos_x_d, z: pos_z_d, offset: ncs_d, count: '0,
			frw: '0, status: 1'b1, last: 1'b0};

		push.first  = have_a || have_b || have_c;
		push.second = (have_a && (have_b || have_c)) || (have_b && have_c);

		if (have_a) begin
			slot0 = ent_a;
			slot1 = have_b ? ent_b : ent_c;
		end else begin
			slot0 = have_b ? ent_b : ent_c;
			slot1 = ent_c;
		end
		slot0.last = !push.second;
		slot1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q      <= '0;
			pos_z_q      <= '0;
			word_ofs_q   <= '0;
			ncs_q        <= '0;
			phase_q      <= rcdb_pkg::PH_COUNT;
			pend_valid_q <= 1'b0;
			pend_ofs_q   <= '0;
			pend_cnt_q   <= '0;
			pend_x_q     <= '0;
			pend_z_q     <= '0;
			done_q       <= 1'b0;
		end else begin
			pos_x_q      <= pos_x_d;
			pos_z_q      <= pos_z_d;
			word_ofs_q   <= word_ofs_d;
			ncs_q        <= ncs_d;
			phase_q      <= phase_d;
			pend_valid_q <= pend_valid_d;
			pend_ofs_q   <= pend_ofs_d;
			pend_cnt_q   <= pend_cnt_d;
			pend_x_q     <= pend_x_d;
			pend_z_q     <= pend_z_d;
			done_q       <= done_d;
		end
	end

endmodule

>>> rtl/core/rcdb_queue.sv
// entry queue: two writes and one read per cycle
module rcdb_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  rcdb_pkg::push_t  push,
	input  rcdb_pkg::entry_t slot0,
	input  rcdb_pkg::entry_t slot1,
	output logic             room2,
	output logic             head_valid,
	output rcdb_pkg::entry_t head,
	input  logic             pop
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned LVL_W = $clog2(DEPTH + 1);

	rcdb_pkg::entry_t   mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [LVL_W-1:0]   level_q;
	logic [PTR_W-1:0]   wr_ptr_1;
	logic [PTR_W-1:0]   wr_ptr_2;
	logic [PTR_W-1:0]   rd_ptr_1;

	// pointer step, wraps at the queue depth (any depth of two or more)
	function automatic logic [PTR_W-1:0] ptr_step(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign wr_ptr_1   = ptr_step(wr_ptr_q);
	assign wr_ptr_2   = ptr_step(wr_ptr_1);
	assign rd_ptr_1   = ptr_step(rd_ptr_q);
	assign room2      = (LVL_W'(DEPTH) - level_q) >= LVL_W'(2);
	assign head_valid = level_q != '0;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.first) begin
			mem_q[wr_ptr_q] <= slot0;
		end
		if (push.second) begin
			mem_q[wr_ptr_1] <= slot1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push.second) begin
				wr_ptr_q <= wr_ptr_2;
			end else if (push.first) begin
				wr_ptr_q <= wr_ptr_1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_1;
			end
			level_q <= level_q + LVL_W'(push.first) + LVL_W'(push.second)
				- LVL_W'(pop);
		end
	end

endmodule

>>> rtl/core/rle_column_directory_builder_top.sv
// column directory builder top level: config registers, front end and entry queue
// an entry is registered into the queue with the word that completes it, then offered in order
// throughput: one slab word per cycle; entries leave at one per cycle while out_ready is high
// entries wait in a QUEUE_DEPTH queue; in_ready drops only while fewer than two slots are free
// reset: asynchronous, clears the walk state, queue and registers (both sides read 1)
`include "rle_column_directory_builder_top_macros.svh"
module rle_column_directory_builder_top #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write port
	input  logic                               cfg_we,
	input  logic [rcdb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rcdb_pkg::SIDE_W-1:0]        cfg_data,
	// slab word stream
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [rcdb_pkg::WORD_W-1:0]        slab_word,
	input  logic                               end_of_stream,
	// directory entries
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [rcdb_pkg::POS_W-1:0]         column_x,
	output logic [rcdb_pkg::POS_W-1:0]         column_z,
	output logic [rcdb_pkg::OFS_W-1:0]         column_offset,
	output logic [rcdb_pkg::WORD_W-1:0]        run_count,
	output logic [rcdb_pkg::WORD_W-1:0]        first_run_word,
	output logic                               entry_status,
	output logic                               last_of_run
);

	// map sides, stored already clamped to the legal range
	logic [rcdb_pkg::SIDE_W-1:0] side_x_q;
	logic [rcdb_pkg::SIDE_W-1:0] side_z_q;

	logic             in_xact;
	logic             room2;
	rcdb_pkg::push_t  push;
	rcdb_pkg::entry_t slot0;
	rcdb_pkg::entry_t slot1;
	rcdb_pkg::entry_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_x_q <= rcdb_pkg::SIDE_W'(1);
			side_z_q <= rcdb_pkg::SIDE_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				rcdb_pkg::CFG_WIDTH_X: side_x_q <= rcdb_pkg::side_clamp(cfg_data);
				rcdb_pkg::CFG_DEPTH_Z: side_z_q <= rcdb_pkg::side_clamp(cfg_data);
				default: begin
				end
			endcase
		end
	end

	// the front end can always take a word when the queue has room for the
	// worst case of two entries from one transaction
	assign in_ready = room2;
	assign in_xact  = in_valid && in_ready;

	// front end: offset tracking, column boundaries, entry formation
	rcdb_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (in_xact),
		.slab_word     (slab_word),
		.end_of_stream (end_of_stream),
		.side_x        (side_x_q),
		.side_z        (side_z_q),
		.push          (push),
		.slot0         (slot0),
		.slot1         (slot1)
	);

	// back end: queue drains one entry per output transaction
	rcdb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.slot0      (slot0),
		.slot1      (slot1),
		.room2      (room2),
		.head_valid (out_valid),
		.head       (head),
		.pop        (out_valid && out_ready)
	);

	assign column_x       = head.x;
	assign column_z       = head.z;
	assign column_offset  = head.offset;
	assign run_count      = head.count;
	assign first_run_word = head.frw;
	assign entry_status   = head.status;
	assign last_of_run    = head.last;

	// entries are only formed from an accepted word
	`RCDB_ASSERT_IMPLIES(a_push_needs_xact, clk, arst_n, push.first, in_xact)
	// a second entry never comes without a first
	`RCDB_ASSERT_IMPLIES(a_push_order, clk, arst_n, push.second, push.first)
	// after the final word the directory is closed for good
	`RCDB_ASSERT_NEXT(a_quiet_after_end, clk, arst_n, in_xact && end_of_stream, !push.first)

endmodule
